FILE: sv/oetg_pkg.sv
package oetg_pkg;

    // divider: unsigned numerator and quotient, unsigned denominator
    localparam int DIV_NW = 56;
    localparam int DIV_DW = 36;

    // square root: input width and root width
    localparam int SQ_IW = 64;
    localparam int SQ_RW = 32;

    // scale applied before both square roots
    localparam int SQRT_SHIFT = 18;

    // signed 20 bit coordinate limits, as magnitudes
    localparam logic [DIV_NW-1:0] COORD_POS_MAX = DIV_NW'(524287);
    localparam logic [DIV_NW-1:0] COORD_NEG_MAG = DIV_NW'(524288);

    // configuration register indexes
    localparam logic REG_COLLINEAR = 1'b0;
    localparam logic REG_MIDPOINT  = 1'b1;

    // side codes
    localparam logic [1:0] SIDE_AB = 2'd0;
    localparam logic [1:0] SIDE_BC = 2'd1;
    localparam logic [1:0] SIDE_CA = 2'd2;

    typedef enum logic [1:0] {
        ST_FRESH = 2'd0,
        ST_HELD  = 2'd1,
        ST_NONE  = 2'd2
    } status_t;

endpackage

FILE: sv/oetg_div.sv
module oetg_div import oetg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_NW-1:0] quo
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              fits;

    // one quotient bit a cycle, restoring
    assign shifted = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(DIV_NW - 1);
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
                quo_reg <= {quo_reg[DIV_NW-2:0], fits};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: sv/oetg_sqrt.sv
module oetg_sqrt import oetg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SQ_IW-1:0] din,
    output logic             done,
    output logic [SQ_RW-1:0] root
);

    localparam int CNT_W = $clog2(SQ_RW);

    logic [SQ_IW-1:0] x_reg;
    logic [SQ_RW:0]   rem_reg;
    logic [SQ_RW-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SQ_RW+2:0] shifted;
    logic [SQ_RW+2:0] trial;
    logic [SQ_RW+2:0] diff;
    logic             fits;

    // one root bit a cycle, two input bits consumed
    assign shifted = {rem_reg, x_reg[SQ_IW-1:SQ_IW-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                x_reg    <= din;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(SQ_RW - 1);
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[SQ_RW:0] : shifted[SQ_RW:0];
                root_reg <= {root_reg[SQ_RW-2:0], fits};
                x_reg    <= {x_reg[SQ_IW-3:0], 2'b00};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: sv/outer_equilateral_triangle_geometry_unit.sv
// a valid item passes through 14 divides, 6 square roots, 43 multiply steps,
//   4 limit checks, 3 row copies and a load before its first result
// a degenerate item leaves early; each result is loaded, then held until m_tready
// items are taken only in idle; most of the run time goes to the shared divider
// reset: synchronous active-low aresetn clears control, held_valid, limits to 1
module outer_equilateral_triangle_geometry_unit import oetg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // apex_x, apex_y, centroid_x, centroid_y
    output logic [79:0] m_tdata,
    // side_index, status
    output logic [3:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [3:0] {
        P_IDLE, P_ITEM, P_ICHK, P_DIV, P_SIDE, P_SCHK, P_SQ, P_MAC,
        P_COMMIT, P_LOAD, P_OUT
    } phase_t;

    typedef enum logic [2:0] {
        DV_CCX, DV_CCY, DV_APX, DV_APY, DV_CEX, DV_CEY
    } divsel_t;

    phase_t  phase_reg;
    divsel_t div_sel_reg;
    status_t status_reg;

    logic [3:0]  step_reg;
    logic [1:0]  side_reg;
    logic [1:0]  out_k_reg;
    logic        sq_sel_reg;
    logic        div_start_reg;
    logic        sq_start_reg;
    logic        held_valid_reg;
    logic [15:0] col_lim_reg;
    logic [15:0] mid_lim_reg;

    // latched vertices
    logic [15:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    // item level intermediates
    logic signed [63:0] tmp_reg;
    logic signed [35:0] det_reg;
    logic signed [35:0] ka_reg;
    logic signed [35:0] kb_reg;
    logic signed [55:0] numx_reg;
    logic signed [55:0] numy_reg;
    logic signed [19:0] ccx_reg;
    logic signed [19:0] ccy_reg;

    // side level intermediates
    logic               dir_reg;
    logic signed [22:0] cmx_reg;
    logic signed [22:0] cmy_reg;
    logic [44:0]        m2_reg;
    logic [35:0]        l2_reg;
    logic [31:0]        limsq_reg;
    logic [26:0]        h_reg;
    logic [30:0]        mq_reg;
    logic signed [51:0] nx_reg;
    logic signed [51:0] ny_reg;
    logic [48:0]        sxmq_reg;
    logic [48:0]        symq_reg;

    // per side rows: apex_x, apex_y, centroid_x, centroid_y from the low bits up
    logic [79:0] geo_new [3];
    logic [79:0] held_mem [3];

    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;
    logic [3:0]  m_tuser_reg;
    logic        m_tlast_reg;

    // vertex differences and sums for the circumcenter
    logic signed [16:0] d_acx, d_acy, d_bcx, d_bcy;
    logic signed [17:0] s_acx, s_acy, s_bcx, s_bcy;
    logic [35:0]        det_mag;

    assign d_acx = signed'({1'b0, ax_reg}) - signed'({1'b0, cx_reg});
    assign d_acy = signed'({1'b0, ay_reg}) - signed'({1'b0, cy_reg});
    assign d_bcx = signed'({1'b0, bx_reg}) - signed'({1'b0, cx_reg});
    assign d_bcy = signed'({1'b0, by_reg}) - signed'({1'b0, cy_reg});
    assign s_acx = signed'({2'b00, ax_reg} + {2'b00, cx_reg});
    assign s_acy = signed'({2'b00, ay_reg} + {2'b00, cy_reg});
    assign s_bcx = signed'({2'b00, bx_reg} + {2'b00, cx_reg});
    assign s_bcy = signed'({2'b00, by_reg} + {2'b00, cy_reg});
    assign det_mag = det_reg[35] ? 36'(-det_reg) : 36'(det_reg);

    // endpoints of the current side, u to v
    logic [15:0] ux, uy, vx, vy;

    always_comb begin
        unique case (side_reg)
            SIDE_AB: begin
                ux = ax_reg; uy = ay_reg; vx = bx_reg; vy = by_reg;
            end
            SIDE_BC: begin
                ux = bx_reg; uy = by_reg; vx = cx_reg; vy = cy_reg;
            end
            default: begin
                ux = cx_reg; uy = cy_reg; vx = ax_reg; vy = ay_reg;
            end
        endcase
    end

    logic signed [20:0] d_cvx, d_cvy;
    logic signed [16:0] d_uvx, d_uvy;
    logic [16:0]        sx, sy;
    logic signed [22:0] wx, wy;

    assign d_cvx = 21'(ccx_reg) - signed'({5'b0, vx});
    assign d_cvy = 21'(ccy_reg) - signed'({5'b0, vy});
    assign d_uvx = signed'({1'b0, ux}) - signed'({1'b0, vx});
    assign d_uvy = signed'({1'b0, uy}) - signed'({1'b0, vy});
    assign sx    = {1'b0, ux} + {1'b0, vx};
    assign sy    = {1'b0, uy} + {1'b0, vy};
    // doubled offset from circumcenter to side midpoint, before orientation
    assign wx    = signed'({6'b0, sx}) - signed'({{2{ccx_reg[19]}}, ccx_reg, 1'b0});
    assign wy    = signed'({6'b0, sy}) - signed'({{2{ccy_reg[19]}}, ccy_reg, 1'b0});

    // the shared multiplier, operands picked by phase and step
    logic signed [35:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [63:0] prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (phase_reg)
            P_ITEM: begin
                case (step_reg)
                    4'd0: begin mul_a = 36'(d_acx); mul_b = 28'(d_bcy); end
                    4'd1: begin mul_a = 36'(d_bcx); mul_b = 28'(d_acy); end
                    4'd2: begin mul_a = 36'(d_acx); mul_b = 28'(s_acx); end
                    4'd3: begin mul_a = 36'(d_acy); mul_b = 28'(s_acy); end
                    4'd4: begin mul_a = 36'(d_bcx); mul_b = 28'(s_bcx); end
                    4'd5: begin mul_a = 36'(d_bcy); mul_b = 28'(s_bcy); end
                    4'd6: begin mul_a = ka_reg;     mul_b = 28'(d_bcy); end
                    4'd7: begin mul_a = kb_reg;     mul_b = 28'(d_acy); end
                    4'd8: begin mul_a = kb_reg;     mul_b = 28'(d_acx); end
                    default: begin mul_a = ka_reg;  mul_b = 28'(d_bcx); end
                endcase
            end
            P_SIDE: begin
                case (step_reg)
                    4'd0: begin mul_a = 36'(d_cvx); mul_b = 28'(d_uvy); end
                    4'd1: begin mul_a = 36'(d_uvx); mul_b = 28'(d_cvy); end
                    4'd2: begin mul_a = 36'(wx);    mul_b = 28'(wx);    end
                    4'd3: begin mul_a = 36'(wy);    mul_b = 28'(wy);    end
                    4'd4: begin mul_a = 36'(d_uvx); mul_b = 28'(d_uvx); end
                    4'd5: begin mul_a = 36'(d_uvy); mul_b = 28'(d_uvy); end
                    default: begin
                        mul_a = 36'({1'b0, mid_lim_reg});
                        mul_b = 28'({1'b0, mid_lim_reg});
                    end
                endcase
            end
            P_MAC: begin
                case (step_reg)
                    4'd0: begin mul_a = 36'(cmx_reg); mul_b = 28'({1'b0, h_reg}); end
                    4'd1: begin mul_a = 36'(cmy_reg); mul_b = 28'({1'b0, h_reg}); end
                    4'd2: begin mul_a = 36'(mq_reg);  mul_b = 28'(sx);            end
                    default: begin mul_a = 36'(mq_reg); mul_b = 28'(sy);          end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // divider operands: rounded quotient num / den, ties away from zero
    logic signed [DIV_NW-1:0] num_s;
    logic [DIV_NW-1:0]        num_mag;
    logic [DIV_NW-1:0]        div_num;
    logic [DIV_DW-1:0]        div_den;
    logic [DIV_DW-1:0]        div_half;
    logic                     div_neg;
    logic                     div_done;
    logic [DIV_NW-1:0]        div_quo;
    logic [DIV_NW-1:0]        q_neg;
    logic                     q_ok;
    logic [19:0]              q_val;

    always_comb begin
        num_s    = '0;
        div_den  = '0;
        div_half = '0;
        div_neg  = 1'b0;
        unique case (div_sel_reg)
            DV_CCX: begin
                num_s    = numx_reg;
                div_den  = DIV_DW'({det_mag, 1'b0});
                div_half = det_mag;
                div_neg  = numx_reg[DIV_NW-1] ^ det_reg[35];
            end
            DV_CCY: begin
                num_s    = numy_reg;
                div_den  = DIV_DW'({det_mag, 1'b0});
                div_half = det_mag;
                div_neg  = numy_reg[DIV_NW-1] ^ det_reg[35];
            end
            DV_APX, DV_APY: begin
                num_s    = (div_sel_reg == DV_APX)
                         ? signed'({7'b0, sxmq_reg}) + DIV_NW'(nx_reg)
                         : signed'({7'b0, symq_reg}) + DIV_NW'(ny_reg);
                div_den  = DIV_DW'({mq_reg, 1'b0});
                div_half = DIV_DW'(mq_reg);
                div_neg  = num_s[DIV_NW-1];
            end
            DV_CEX, DV_CEY: begin
                num_s    = (div_sel_reg == DV_CEX)
                         ? signed'(DIV_NW'({sxmq_reg, 1'b0}) + DIV_NW'(sxmq_reg))
                           + DIV_NW'(nx_reg)
                         : signed'(DIV_NW'({symq_reg, 1'b0}) + DIV_NW'(symq_reg))
                           + DIV_NW'(ny_reg);
                div_den  = DIV_DW'({mq_reg, 2'b00}) + DIV_DW'({mq_reg, 1'b0});
                div_half = DIV_DW'({mq_reg, 1'b0}) + DIV_DW'(mq_reg);
                div_neg  = num_s[DIV_NW-1];
            end
            default: begin
                num_s    = '0;
                div_den  = '0;
                div_half = '0;
                div_neg  = 1'b0;
            end
        endcase
    end

    assign num_mag = num_s[DIV_NW-1] ? DIV_NW'(-num_s) : DIV_NW'(num_s);
    assign div_num = num_mag + DIV_NW'(div_half);
    assign q_neg   = DIV_NW'(0) - div_quo;
    assign q_ok    = div_neg ? (div_quo <= COORD_NEG_MAG) : (div_quo <= COORD_POS_MAX);
    assign q_val   = div_neg ? q_neg[19:0] : div_quo[19:0];

    oetg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // square root operand: 3 L2 or M2, scaled
    logic [SQ_IW-1:0] sq_din;
    logic             sq_done;
    logic [SQ_RW-1:0] sq_root;

    assign sq_din = sq_sel_reg
                  ? (SQ_IW'(m2_reg) << SQRT_SHIFT)
                  : ((SQ_IW'(l2_reg) + (SQ_IW'(l2_reg) << 1)) << SQRT_SHIFT);

    oetg_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start_reg),
        .din     (sq_din),
        .done    (sq_done),
        .root    (sq_root)
    );

    logic s_accept;
    assign s_accept = s_tvalid && (phase_reg == P_IDLE);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= P_IDLE;
            div_sel_reg    <= DV_CCX;
            status_reg     <= ST_NONE;
            step_reg       <= '0;
            side_reg       <= SIDE_AB;
            out_k_reg      <= SIDE_AB;
            sq_sel_reg     <= 1'b0;
            div_start_reg  <= 1'b0;
            sq_start_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            col_lim_reg    <= 16'd1;
            mid_lim_reg    <= 16'd1;
        end else begin
            div_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_COLLINEAR: col_lim_reg <= cfg_data;
                    REG_MIDPOINT:  mid_lim_reg <= cfg_data;
                    default:       col_lim_reg <= col_lim_reg;
                endcase
            end

            unique case (phase_reg)
                P_IDLE: begin
                    if (s_accept) begin
                        ax_reg    <= s_tdata[15:0];
                        ay_reg    <= s_tdata[31:16];
                        bx_reg    <= s_tdata[47:32];
                        by_reg    <= s_tdata[63:48];
                        cx_reg    <= s_tdata[79:64];
                        cy_reg    <= s_tdata[95:80];
                        step_reg  <= '0;
                        phase_reg <= P_ITEM;
                    end
                end

                // determinant, squared-norm terms and circumcenter numerators
                P_ITEM: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd1: det_reg  <= 36'(tmp_reg - prod);
                        4'd3: ka_reg   <= 36'(tmp_reg + prod);
                        4'd5: kb_reg   <= 36'(tmp_reg + prod);
                        4'd7: numx_reg <= DIV_NW'(tmp_reg - prod);
                        4'd9: begin
                            numy_reg  <= DIV_NW'(tmp_reg - prod);
                            phase_reg <= P_ICHK;
                        end
                        default: tmp_reg <= prod;
                    endcase
                end

                // collinear test
                P_ICHK: begin
                    if (det_mag == '0 || det_mag < 36'(col_lim_reg)) begin
                        status_reg <= held_valid_reg ? ST_HELD : ST_NONE;
                        out_k_reg  <= SIDE_AB;
                        phase_reg  <= P_LOAD;
                    end else begin
                        div_sel_reg   <= DV_CCX;
                        div_start_reg <= 1'b1;
                        phase_reg     <= P_DIV;
                    end
                end

                P_DIV: begin
                    if (div_done) begin
                        if (!q_ok) begin
                            // overflow of circumcenter, apex or centroid
                            status_reg <= held_valid_reg ? ST_HELD : ST_NONE;
                            out_k_reg  <= SIDE_AB;
                            phase_reg  <= P_LOAD;
                        end else begin
                            unique case (div_sel_reg)
                                DV_CCX: begin
                                    ccx_reg       <= q_val;
                                    div_sel_reg   <= DV_CCY;
                                    div_start_reg <= 1'b1;
                                end
                                DV_CCY: begin
                                    ccy_reg   <= q_val;
                                    side_reg  <= SIDE_AB;
                                    step_reg  <= '0;
                                    phase_reg <= P_SIDE;
                                end
                                DV_APX: begin
                                    div_sel_reg   <= DV_APY;
                                    div_start_reg <= 1'b1;
                                end
                                DV_APY: begin
                                    div_sel_reg   <= DV_CEX;
                                    div_start_reg <= 1'b1;
                                end
                                DV_CEX: begin
                                    div_sel_reg   <= DV_CEY;
                                    div_start_reg <= 1'b1;
                                end
                                DV_CEY: begin
                                    if (side_reg == SIDE_CA) begin
                                        out_k_reg <= SIDE_AB;
                                        phase_reg <= P_COMMIT;
                                    end else begin
                                        side_reg  <= side_reg + 2'd1;
                                        step_reg  <= '0;
                                        phase_reg <= P_SIDE;
                                    end
                                end
                                default: phase_reg <= P_IDLE;
                            endcase
                        end
                    end
                end

                // orientation, offset to midpoint, squared lengths
                P_SIDE: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd1: dir_reg <= (tmp_reg - prod) > 64'sd0;
                        4'd2: begin
                            tmp_reg <= prod;
                            cmx_reg <= dir_reg ? wx : -wx;
                            cmy_reg <= dir_reg ? wy : -wy;
                        end
                        4'd3: m2_reg <= 45'(tmp_reg + prod);
                        4'd5: l2_reg <= 36'(tmp_reg + prod);
                        4'd6: begin
                            limsq_reg <= 32'(prod);
                            phase_reg <= P_SCHK;
                        end
                        default: tmp_reg <= prod;
                    endcase
                end

                // circumcenter too close to the side midpoint
                P_SCHK: begin
                    if (m2_reg == '0 || m2_reg < 45'({limsq_reg, 2'b00})) begin
                        status_reg <= held_valid_reg ? ST_HELD : ST_NONE;
                        out_k_reg  <= SIDE_AB;
                        phase_reg  <= P_LOAD;
                    end else begin
                        sq_sel_reg   <= 1'b0;
                        sq_start_reg <= 1'b1;
                        phase_reg    <= P_SQ;
                    end
                end

                P_SQ: begin
                    if (sq_done) begin
                        if (!sq_sel_reg) begin
                            h_reg        <= sq_root[26:0];
                            sq_sel_reg   <= 1'b1;
                            sq_start_reg <= 1'b1;
                        end else begin
                            mq_reg    <= sq_root[30:0];
                            step_reg  <= '0;
                            phase_reg <= P_MAC;
                        end
                    end
                end

                P_MAC: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd0: nx_reg   <= 52'(prod);
                        4'd1: ny_reg   <= 52'(prod);
                        4'd2: sxmq_reg <= 49'(prod);
                        default: begin
                            symq_reg      <= 49'(prod);
                            div_sel_reg   <= DV_APX;
                            div_start_reg <= 1'b1;
                            phase_reg     <= P_DIV;
                        end
                    endcase
                end

                // copy the new rows into the held store, one row a cycle
                P_COMMIT: begin
                    if (out_k_reg == SIDE_CA) begin
                        held_valid_reg <= 1'b1;
                        status_reg     <= ST_FRESH;
                        out_k_reg      <= SIDE_AB;
                        phase_reg      <= P_LOAD;
                    end else begin
                        out_k_reg <= out_k_reg + 2'd1;
                    end
                end

                P_LOAD: begin
                    m_tdata_reg  <= (status_reg == ST_NONE) ? '0 : held_mem[out_k_reg];
                    m_tuser_reg  <= {status_reg, out_k_reg};
                    m_tlast_reg  <= (out_k_reg == SIDE_CA);
                    m_tvalid_reg <= 1'b1;
                    phase_reg    <= P_OUT;
                end

                P_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (out_k_reg == SIDE_CA) begin
                            phase_reg <= P_IDLE;
                        end else begin
                            out_k_reg <= out_k_reg + 2'd1;
                            phase_reg <= P_LOAD;
                        end
                    end
                end

                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    // row stores: new geometry by side, held geometry by commit/output index
    always_ff @(posedge aclk) begin
        if (phase_reg == P_DIV && div_done && q_ok) begin
            case (div_sel_reg)
                DV_APX:  geo_new[side_reg][19:0]  <= q_val;
                DV_APY:  geo_new[side_reg][39:20] <= q_val;
                DV_CEX:  geo_new[side_reg][59:40] <= q_val;
                DV_CEY:  geo_new[side_reg][79:60] <= q_val;
                default: ;
            endcase
        end
        if (phase_reg == P_COMMIT) begin
            held_mem[out_k_reg] <= geo_new[out_k_reg];
        end
    end

    assign s_tready  = (phase_reg == P_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;
    assign cfg_ready = 1'b1;

    // no item taken while a result is on offer
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("still ready after accept");

    // fresh or held results need a committed construction
    a_fresh_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:2] == ST_FRESH || m_tuser[3:2] == ST_HELD)
        |-> held_valid_reg)
        else $error("geometry emitted without a committed construction");

    // last marks exactly the third side
    a_last_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] == SIDE_CA)))
        else $error("last flag does not match side");

endmodule
